// ===== hw/rtl/rslf_pkg.sv =====
// ----------------------------------------------------------------------------
// rslf_pkg
// Shared types, constants and helpers for the scanline run pattern finder.
// ----------------------------------------------------------------------------
package rslf_pkg;

   // Frame geometry
   localparam int MAX_ROW_WIDTH = 2048;
   localparam int MAX_ROWS      = 2048;
   localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
   localparam int ROW_W         = $clog2(MAX_ROWS);
   localparam int LUMA_W        = 8;

   // Run window: four stored runs plus the run being closed
   localparam int WIN_DEPTH     = 4;
   localparam int WIN_IDX_W     = $clog2(WIN_DEPTH);
   localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
   localparam int SPAN_COUNT    = WIN_DEPTH + 1;
   localparam int SPAN_IDX_W    = $clog2(SPAN_COUNT);
   localparam int SEQ_W         = $clog2(SPAN_COUNT + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // Configuration port
   localparam int CSR_INDEX_W   = 2;
   localparam logic [LUMA_W-1:0] THRESHOLD_RESET  = 8'd128;
   localparam logic [LUMA_W-1:0] MIN_EXTENT_RESET = 8'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LUMA_THRESHOLD = 2'd0,
      CSR_MIN_RUN_EXTENT = 2'd1
   } csr_index_type;

   // Result codes
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_SPAN  = 1'b1;
   localparam logic [LUMA_W-1:0] LUMA_WHITE = 8'd255;
   localparam logic [LUMA_W-1:0] LUMA_BLACK = 8'd0;

   // One run of equal color
   typedef struct packed {
      logic [COL_W-1:0] start;
      logic [COL_W-1:0] stop;
      logic             white;
   } run_type;

   // Everything the back end needs to emit the results of one pixel
   typedef struct packed {
      logic                       white;
      logic [ROW_W-1:0]           row;
      logic [COL_W-1:0]           col;
      logic                       match;
      run_type [SPAN_COUNT-1:0]   runs;
   } item_type;

   // a near b: b - a/2 < a < b + a/2, a/2 rounded down
   function automatic logic near_half(input logic [COL_W-1:0] a,
                                      input logic [COL_W-1:0] b);
      logic [COL_W:0] half;
      logic [COL_W:0] a_x;
      logic [COL_W:0] b_x;
      half = {2'b00, a[COL_W-1:1]};
      a_x  = {1'b0, a};
      b_x  = {1'b0, b};
      return ((a_x + half) > b_x) && (a_x < (b_x + half));
   endfunction

endpackage

// ===== hw/rtl/rslf_front.sv =====
// ----------------------------------------------------------------------------
// rslf_front
// Binarizes pixels, tracks runs per row, keeps the run window and tests it
// for the finder shape. Each accepted pixel pushes one item to the queue.
// ----------------------------------------------------------------------------
module rslf_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [rslf_pkg::LUMA_W-1:0]      req_luma,
   input  logic                           req_row_end,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rslf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rslf_pkg::LUMA_W-1:0]      csr_wdata,
   input  logic                           q_full,
   output logic                           push,
   output rslf_pkg::item_type             push_item
);
   import rslf_pkg::*;

   // Configuration
   logic [LUMA_W-1:0] thresh_ff, thresh_in;
   logic [LUMA_W-1:0] min_ext_ff, min_ext_in;

   // Row and run tracking
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             run_active_ff, run_active_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic [COL_W-1:0] run_stop_ff, run_stop_in;
   logic             run_white_ff, run_white_in;

   // Window of kept runs, extents kept alongside
   run_type          win_ff [WIN_DEPTH];
   run_type          win_in [WIN_DEPTH];
   logic [COL_W-1:0] win_ext_ff [WIN_DEPTH];
   logic [COL_W-1:0] win_ext_in [WIN_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic             accept;
   logic             white;
   logic             change;
   logic             close_a;
   logic             close_b;
   run_type          cls_run;
   logic [COL_W-1:0] cls_ext;
   logic [LUMA_W-1:0] min_eff;
   logic             kept;
   logic             win_full;
   logic             match;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   // Classify the pixel and pick the run that closes on it
   always_comb begin
      white    = (req_luma >= thresh_ff);
      change   = !run_active_ff || (white != run_white_ff);
      close_a  = run_active_ff && (white != run_white_ff);
      close_b  = req_row_end && !change;
      cls_run.start = run_start_ff;
      cls_run.stop  = close_a ? run_stop_ff : column_ff;
      cls_run.white = run_white_ff;
      cls_ext  = cls_run.stop - cls_run.start;
      min_eff  = (min_ext_ff == '0) ? LUMA_W'(1) : min_ext_ff;
      kept     = (close_a || close_b) && (cls_ext >= COL_W'(min_eff));
      win_full = (fill_ff >= FILL_W'(WIN_DEPTH));
      match    = kept && win_full && !win_ff[0].white
                 && near_half(win_ext_ff[0], cls_ext)
                 && near_half(win_ext_ff[1], win_ext_ff[3])
                 && (win_ext_ff[1] < win_ext_ff[2])
                 && (win_ext_ff[2] > win_ext_ff[3]);
   end

   // Item for the back end
   always_comb begin
      push_item.white = white;
      push_item.row   = row_ff;
      push_item.col   = column_ff;
      push_item.match = match;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         push_item.runs[i] = win_ff[i];
      end
      push_item.runs[WIN_DEPTH] = cls_run;
   end

   // Next state
   always_comb begin
      thresh_in     = thresh_ff;
      min_ext_in    = min_ext_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      run_active_in = run_active_ff;
      run_start_in  = run_start_ff;
      run_stop_in   = run_stop_ff;
      run_white_in  = run_white_ff;
      win_in        = win_ff;
      win_ext_in    = win_ext_ff;
      fill_in       = fill_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_LUMA_THRESHOLD: thresh_in  = csr_wdata;
            CSR_MIN_RUN_EXTENT: min_ext_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         // run tracking
         if (change) begin
            run_active_in = 1'b1;
            run_start_in  = column_ff;
            run_stop_in   = column_ff;
            run_white_in  = white;
         end else begin
            run_stop_in   = column_ff;
         end

         // window update on a kept run
         if (kept) begin
            if (win_full) begin
               for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                  win_in[i]     = win_ff[i+1];
                  win_ext_in[i] = win_ext_ff[i+1];
               end
               win_in[WIN_DEPTH-1]     = cls_run;
               win_ext_in[WIN_DEPTH-1] = cls_ext;
            end else begin
               win_in[fill_ff[WIN_IDX_W-1:0]]     = cls_run;
               win_ext_in[fill_ff[WIN_IDX_W-1:0]] = cls_ext;
               fill_in = fill_ff + 1'b1;
            end
         end

         // row bookkeeping
         if (req_row_end) begin
            run_active_in = 1'b0;
            fill_in       = '0;
            column_in     = '0;
            row_in        = (row_ff == ROW_W'(MAX_ROWS - 1)) ? '0 : row_ff + 1'b1;
         end else if (column_ff != COL_W'(MAX_ROW_WIDTH - 1)) begin
            column_in     = column_ff + 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff     <= THRESHOLD_RESET;
         min_ext_ff    <= MIN_EXTENT_RESET;
         column_ff     <= '0;
         row_ff        <= '0;
         run_active_ff <= 1'b0;
         fill_ff       <= '0;
      end else begin
         thresh_ff     <= thresh_in;
         min_ext_ff    <= min_ext_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         run_active_ff <= run_active_in;
         fill_ff       <= fill_in;
      end
   end

   // Run and window payload
   always_ff @(posedge clock) begin
      run_start_ff <= run_start_in;
      run_stop_ff  <= run_stop_in;
      run_white_ff <= run_white_in;
      win_ff       <= win_in;
      win_ext_ff   <= win_ext_in;
   end

endmodule

// ===== hw/rtl/rslf_queue.sv =====
// ----------------------------------------------------------------------------
// rslf_queue
// Short FIFO of items between the front and the back end.
// ----------------------------------------------------------------------------
module rslf_queue #(
   parameter int DEPTH = rslf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rslf_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output rslf_pkg::item_type  head_item
);
   import rslf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/rslf_back.sv =====
// ----------------------------------------------------------------------------
// rslf_back
// Walks the queue head through its results: the pixel, then the five spans
// on a match, into a registered result stage.
// ----------------------------------------------------------------------------
module rslf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  rslf_pkg::item_type          head_item,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic [rslf_pkg::LUMA_W-1:0] rsp_out_luma,
   output logic [rslf_pkg::ROW_W-1:0]  rsp_row_index,
   output logic [rslf_pkg::COL_W-1:0]  rsp_span_start,
   output logic [rslf_pkg::COL_W-1:0]  rsp_span_stop,
   output logic                        rsp_last
);
   import rslf_pkg::*;

   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic                  valid_ff, valid_in;
   logic                  kind_ff, kind_in;
   logic [LUMA_W-1:0]     luma_ff, luma_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      start_ff, start_in;
   logic [COL_W-1:0]      stop_ff, stop_in;
   logic                  last_ff, last_in;

   logic                  load;
   logic [SPAN_IDX_W-1:0] span_idx;
   run_type               span;

   assign load     = head_valid && (!valid_ff || !rsp_stall);
   assign span_idx = SPAN_IDX_W'(seq_ff - 1'b1);
   assign span     = head_item.runs[span_idx];
   assign pop      = load && last_in;

   // Build the next result from the head item
   always_comb begin
      row_in = head_item.row;
      if (seq_ff == '0) begin
         kind_in  = KIND_PIXEL;
         luma_in  = head_item.white ? LUMA_WHITE : LUMA_BLACK;
         start_in = head_item.col;
         stop_in  = '0;
         last_in  = !head_item.match;
      end else begin
         kind_in  = KIND_SPAN;
         luma_in  = span.white ? LUMA_BLACK : LUMA_WHITE;
         start_in = span.start;
         stop_in  = span.stop;
         last_in  = (seq_ff == SEQ_W'(SPAN_COUNT));
      end
   end

   // Sequence counter and output valid
   always_comb begin
      seq_in   = seq_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         seq_in   = last_in ? '0 : seq_ff + 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         luma_ff  <= luma_in;
         row_ff   <= row_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_out_luma   = luma_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_span_start = start_ff;
   assign rsp_span_stop  = stop_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== hw/rtl/scanline_run_pattern_finder.sv =====
// ----------------------------------------------------------------------------
// scanline_run_pattern_finder
// Binarizes raster pixels, run-length codes each row and reports five-run
// finder shapes as draw spans after the binarized pixel.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  luma, row_end
//   rsp_     out        rsp_valid / rsp_stall  kind, out_luma, row_index,
//                                              span_start, span_stop, last
//   csr_     in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One pixel is taken per cycle while req_stall is low; it gives one result, or six
// when a finder shape closes on it, and the rsp_ register stage emits one result
// per cycle while rsp_stall is low. With the back end idle, a pixel's first
// result passes the queue write, then the rsp_ register, before rsp_valid rises.
// A match holds the queue head until its six results are loaded; with pixels
// arriving every cycle the item queue (QUEUE_DEPTH entries) fills and req_ stalls.
// Synchronous reset clears control state and loads the register defaults.
// req_stall rises only while the item queue is full.
// ----------------------------------------------------------------------------
module scanline_run_pattern_finder #(
   parameter int QUEUE_DEPTH = rslf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rslf_pkg::LUMA_W-1:0]       req_luma,
   input  logic                              req_row_end,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [rslf_pkg::LUMA_W-1:0]       rsp_out_luma,
   output logic [rslf_pkg::ROW_W-1:0]        rsp_row_index,
   output logic [rslf_pkg::COL_W-1:0]        rsp_span_start,
   output logic [rslf_pkg::COL_W-1:0]        rsp_span_stop,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rslf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rslf_pkg::LUMA_W-1:0]       csr_wdata
);
   import rslf_pkg::*;

   logic     q_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     head_valid;
   item_type head_item;

   // Classification and run window
   rslf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_luma    (req_luma),
      .req_row_end (req_row_end),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item)
   );

   // Item queue
   rslf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Result sequencing
   rslf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_luma   (rsp_out_luma),
      .rsp_row_index  (rsp_row_index),
      .rsp_span_start (rsp_span_start),
      .rsp_span_stop  (rsp_span_stop),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: scanline run pattern finder testbench
// Feeds raster pixels through the req_ channel, predicts the binarized
// pixel and any finder-shape spans for every accepted pixel, and compares
// each rsp_ transfer field by field in order. Covers threshold extremes,
// zero minimum extent, runs closed at row end and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rslf_pkg::*;

   localparam int HOLDOFF_AT     = 28;
   localparam int HOLDOFF_CYCLES = 40;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [LUMA_W-1:0] luma;
      logic              row_end;
   } pixel_type;

   typedef struct packed {
      logic              kind;
      logic [LUMA_W-1:0] out_luma;
      logic [ROW_W-1:0]  row_index;
      logic [COL_W-1:0]  span_start;
      logic [COL_W-1:0]  span_stop;
      logic              last;
   } result_type;

   typedef struct {
      bit white;
      int len;
   } run_plan_type;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   // DUT connections
   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [LUMA_W-1:0]      req_luma    = '0;
   logic                   req_row_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic                   rsp_kind;
   logic [LUMA_W-1:0]      rsp_out_luma;
   logic [ROW_W-1:0]       rsp_row_index;
   logic [COL_W-1:0]       rsp_span_start;
   logic [COL_W-1:0]       rsp_span_stop;
   logic                   rsp_last;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_LUMA_THRESHOLD;
   logic [LUMA_W-1:0]      csr_wdata   = '0;

   // stimulus and scoreboard
   pixel_type      pixel_feed[$];
   result_type     awaited_outputs[$];
   result_type     step_outputs[$];
   run_plan_type   row_plan[$];
   int             pixels_queued   = 0;
   int             pixels_accepted = 0;
   int             mismatch_count  = 0;
   logic           req_taken       = 1'b0;

   // driver and receiver pacing
   int             burst_left      = 0;
   int             gap_left        = 0;
   int             holdoff_left    = 0;
   bit             holdoff_done    = 1'b0;
   stall_mode_type stall_mode      = STALL_NONE;
   int             stall_mode_left = 0;

   // predictor state
   logic [LUMA_W-1:0] thr_cfg;
   logic [LUMA_W-1:0] min_extent_cfg;
   logic [COL_W-1:0]  next_col;
   logic [ROW_W-1:0]  cur_row;
   logic              run_open;
   logic [COL_W-1:0]  run_first;
   logic [COL_W-1:0]  run_last;
   logic              run_is_white;
   run_type           kept_runs[WIN_DEPTH];
   int                kept_count;

   scanline_run_pattern_finder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_luma       (req_luma),
      .req_row_end    (req_row_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_out_luma   (rsp_out_luma),
      .rsp_row_index  (rsp_row_index),
      .rsp_span_start (rsp_span_start),
      .rsp_span_stop  (rsp_span_stop),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic bit within_half(input int a, input int b);
      int h;
      h = a / 2;
      return (a > b - h) && (a < b + h);
   endfunction

   task automatic clear_predictor();
      thr_cfg        = THRESHOLD_RESET;
      min_extent_cfg = MIN_EXTENT_RESET;
      next_col       = '0;
      cur_row        = '0;
      run_open       = 1'b0;
      run_first      = '0;
      run_last       = '0;
      run_is_white   = 1'b0;
      kept_count     = 0;
      for (int i = 0; i < WIN_DEPTH; i++) kept_runs[i] = '0;
   endtask

   // close a run, keep it if wide enough, test the five-run window
   task automatic close_run_and_match(input logic [COL_W-1:0] first_x,
                                      input logic [COL_W-1:0] last_x,
                                      input logic white);
      int         min_ext;
      int         ext[5];
      run_type    win[5];
      result_type span;
      min_ext = (min_extent_cfg == 0) ? 1 : int'(min_extent_cfg);
      if (last_x < first_x || int'(last_x) - int'(first_x) < min_ext) return;
      win[4].start = first_x;
      win[4].stop  = last_x;
      win[4].white = white;
      if (kept_count >= WIN_DEPTH) begin
         for (int i = 0; i < WIN_DEPTH; i++) win[i] = kept_runs[i];
         for (int i = 0; i < 5; i++) ext[i] = int'(win[i].stop) - int'(win[i].start);
         if (!win[0].white && within_half(ext[0], ext[4]) &&
             within_half(ext[1], ext[3]) && ext[1] < ext[2] && ext[2] > ext[3]) begin
            for (int i = 0; i < 5; i++) begin
               if (step_outputs.size() < 6) begin
                  span.kind       = KIND_SPAN;
                  span.out_luma   = win[i].white ? LUMA_BLACK : LUMA_WHITE;
                  span.row_index  = cur_row;
                  span.span_start = win[i].start;
                  span.span_stop  = win[i].stop;
                  span.last       = 1'b0;
                  step_outputs.push_back(span);
               end
            end
         end
         for (int i = 0; i < WIN_DEPTH - 1; i++) kept_runs[i] = kept_runs[i + 1];
         kept_runs[WIN_DEPTH - 1] = win[4];
      end else begin
         kept_runs[kept_count] = win[4];
         kept_count++;
      end
   endtask

   // one accepted pixel: binarized pixel first, then any matched spans
   task automatic binarize_and_find(input logic [LUMA_W-1:0] luma,
                                    input logic row_end);
      logic             white;
      logic [COL_W-1:0] col;
      result_type       r;
      white = (luma >= thr_cfg);
      col   = next_col;
      step_outputs.delete();
      r.kind       = KIND_PIXEL;
      r.out_luma   = white ? LUMA_WHITE : LUMA_BLACK;
      r.row_index  = cur_row;
      r.span_start = col;
      r.span_stop  = '0;
      r.last       = 1'b0;
      step_outputs.push_back(r);

      if (!run_open || white != run_is_white) begin
         if (run_open) close_run_and_match(run_first, run_last, run_is_white);
         run_open     = 1'b1;
         run_first    = col;
         run_last     = col;
         run_is_white = white;
      end else begin
         run_last = col;
      end

      if (row_end) begin
         close_run_and_match(run_first, run_last, run_is_white);
         run_open   = 1'b0;
         kept_count = 0;
         next_col   = '0;
         cur_row    = (int'(cur_row) == MAX_ROWS - 1) ? '0 : cur_row + 1'b1;
      end else if (int'(col) != MAX_ROW_WIDTH - 1) begin
         next_col = col + 1'b1;
      end

      r = step_outputs.pop_back();
      r.last = 1'b1;
      step_outputs.push_back(r);
      foreach (step_outputs[i]) awaited_outputs.push_back(step_outputs[i]);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [LUMA_W-1:0] pick_luma(input bit white);
      if (white) return LUMA_W'($urandom_range(int'(thr_cfg), 255));
      if (thr_cfg != 0) return LUMA_W'($urandom_range(0, int'(thr_cfg) - 1));
      return LUMA_W'($urandom_range(0, 255));
   endfunction

   task automatic queue_pixel(input logic [LUMA_W-1:0] luma, input logic row_end);
      pixel_type p;
      p.luma    = luma;
      p.row_end = row_end;
      pixel_feed.push_back(p);
      pixels_queued++;
   endtask

   task automatic add_run(input bit white, input int len);
      run_plan_type r;
      r.white = white;
      r.len   = len;
      row_plan.push_back(r);
   endtask

   // turn the planned runs into pixels, row end on the final one
   task automatic emit_row();
      int n;
      n = row_plan.size();
      for (int k = 0; k < n; k++) begin
         for (int p = 0; p < row_plan[k].len; p++) begin
            queue_pixel(pick_luma(row_plan[k].white),
                        (k == n - 1) && (p == row_plan[k].len - 1));
         end
      end
      row_plan.delete();
   endtask

   // mostly finder shapes with jitter, some broken runs and pixel noise
   task automatic queue_random_row(input int unit);
      int shape;
      int count;
      bit c;
      shape = $urandom_range(0, 9);
      if (shape <= 5) begin
         if ($urandom_range(0, 1)) add_run(1'b1, unit + $urandom_range(0, 2));
         add_run(1'b0, unit + $urandom_range(0, 2));
         add_run(1'b1, unit + $urandom_range(0, 2));
         add_run(1'b0, 2 * unit + $urandom_range(0, unit));
         add_run(1'b1, unit + $urandom_range(0, 2));
         add_run(1'b0, unit + $urandom_range(0, 2));
         if ($urandom_range(0, 2) != 0) add_run(1'b1, $urandom_range(1, unit));
      end else if (shape <= 7) begin
         c = 1'($urandom_range(0, 1));
         count = $urandom_range(3, 7);
         repeat (count) begin
            add_run(c, $urandom_range(1, 3 * unit));
            c = !c;
         end
      end else begin
         count = $urandom_range(1, 12);
         repeat (count) add_run(1'($urandom_range(0, 1)), 1);
      end
      emit_row();
   endtask

   task automatic queue_random_rows(input int unit_lo, input int unit_hi, input int target);
      int goal;
      goal = pixels_queued + target;
      while (pixels_queued < goal) queue_random_row($urandom_range(unit_lo, unit_hi));
   endtask

   task automatic write_register(input csr_index_type idx, input logic [LUMA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_LUMA_THRESHOLD) thr_cfg = value;
      else min_extent_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until all pixels are in and every output has come back
   task automatic drain_outputs();
      do @(posedge clock);
      while (pixel_feed.size() != 0 || req_valid || awaited_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------
   // Pixel driver: bursts with random gaps, holds a stalled transfer
   // ------------------------------------------------------------------
   always @(negedge clock) begin : pixel_driver
      pixel_type nxt;
      if (req_valid && !req_taken) begin
         // stalled: payload stays put
      end else if (gap_left > 0) begin
         gap_left  <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pixel_feed.size() > 0) begin
         nxt = pixel_feed.pop_front();
         req_valid   <= 1'b1;
         req_luma    <= nxt.luma;
         req_row_end <= nxt.row_end;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Output stall pattern, with one long hold-off to fill the block
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && pixels_accepted >= HOLDOFF_AT) begin
         rsp_stall    <= 1'b1;
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_CYCLES;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode      <= stall_mode_type'($urandom_range(0, 2));
            stall_mode_left <= $urandom_range(16, 48);
         end else begin
            stall_mode_left <= stall_mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default:     rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check result transfers, predict on pixel transfers
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outputs.size() == 0) begin
               report_mismatch("result with nothing awaited, span_start",
                               32'(rsp_span_start), 0);
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
               if (rsp_out_luma !== want.out_luma)
                  report_mismatch("out_luma", 32'(rsp_out_luma), 32'(want.out_luma));
               if (rsp_row_index !== want.row_index)
                  report_mismatch("row_index", 32'(rsp_row_index), 32'(want.row_index));
               if (rsp_span_start !== want.span_start)
                  report_mismatch("span_start", 32'(rsp_span_start),
                                  32'(want.span_start));
               if (rsp_span_stop !== want.span_stop)
                  report_mismatch("span_stop", 32'(rsp_span_stop), 32'(want.span_stop));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) begin
            binarize_and_find(req_luma, req_row_end);
            pixels_accepted <= pixels_accepted + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      clear_predictor();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: threshold edges, then a finder shape closed by row end
      write_register(CSR_LUMA_THRESHOLD, 8'd128);
      write_register(CSR_MIN_RUN_EXTENT, 8'd1);
      queue_pixel(8'd0, 1'b1);
      queue_pixel(8'd255, 1'b1);
      queue_pixel(8'd127, 1'b1);
      queue_pixel(8'd128, 1'b1);
      add_run(1'b0, 3);
      add_run(1'b1, 3);
      add_run(1'b0, 6);
      add_run(1'b1, 3);
      add_run(1'b0, 3);
      emit_row();
      drain_outputs();

      // random rows, narrow runs kept
      queue_random_rows(3, 4, 16);
      drain_outputs();

      // top threshold, zero minimum extent
      write_register(CSR_LUMA_THRESHOLD, 8'd255);
      write_register(CSR_MIN_RUN_EXTENT, 8'd0);
      queue_random_rows(2, 3, 10);
      drain_outputs();

      // bottom threshold: every pixel white
      write_register(CSR_LUMA_THRESHOLD, 8'd0);
      write_register(CSR_MIN_RUN_EXTENT, 8'd2);
      queue_random_rows(2, 3, 6);
      drain_outputs();

      // random rows, random registers
      write_register(CSR_LUMA_THRESHOLD, LUMA_W'($urandom_range(1, 254)));
      write_register(CSR_MIN_RUN_EXTENT, LUMA_W'($urandom_range(1, 3)));
      queue_random_rows(3, 4, 12);
      drain_outputs();

      if (mismatch_count == 0) begin
         $display("scanline_run_pattern_finder: match");
      end else begin
         $display("scanline_run_pattern_finder: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #5000000;
      $display("scanline_run_pattern_finder: mismatch");
      $finish;
   end

endmodule
